/* hdl/rmsmu_pkg.sv */
package rmsmu_pkg;

	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 80;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int EPS_W       = 17;
	localparam int LR_W        = 21;
	localparam int BATCH_W     = 16;
	localparam int PIDX_W      = 10;

	localparam logic [16:0] ONE_Q16      = 17'h10000;
	localparam logic [16:0] MOMENTUM_RST = 17'd58982;
	localparam logic [16:0] RMS_DECAY_RST = 17'd64881;
	localparam logic [16:0] EPSILON_RST  = 17'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOMENTUM  = 3'd0,
		REG_RMS_DECAY = 3'd1,
		REG_EPSILON   = 3'd2,
		REG_MAXIMIZE  = 3'd3,
		REG_ACCUM     = 3'd4
	} cfg_reg_t;

endpackage

/* hdl/rmsprop_momentum_weight_update.sv */
// RMSProp-with-momentum weight updater for Q-format fixed point. One parameter beat enters per
// cycle while the pipeline is not stalled, and its result leaves through the pipelined batch
// divider, square root and scaling divider. A non-recurrent beat whose slot matches a
// non-recurrent beat still ahead of it, before that beat has written its velocity, waits at
// the hazard stage, so back-to-back updates of one slot are serialized.
// After reset both per-parameter stores are zeroed in a sweep over all NUM_PARAMS slots, during
// which no beat is accepted; configuration writes are taken at any time but must only be
// issued while the pipeline is empty.
module rmsprop_momentum_weight_update #(
	parameter int NUM_PARAMS = 1024,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// param_index[9:0], gradient_in[41:10], weight_in[73:42], learning_rate[94:74],
	// batch_size[110:95], zero pad.
	input  logic [rmsmu_pkg::IN_TDATA_W-1:0]     s_tdata,
	// is_recurrent[0].
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// param_index_out[9:0], weight_out[41:10], gradient_out[73:42], zero pad.
	output logic [rmsmu_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// updated[0].
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rmsmu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rmsmu_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import rmsmu_pkg::*;

	localparam int F        = FRAC_BITS;
	localparam int SW       = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam int RCP_SH   = 20;
	localparam int RCP      = (1 << RCP_SH) / NUM_PARAMS;
	localparam int DIV_K    = 4;
	localparam int SQ_K     = 3;
	localparam int NB       = (32 + DIV_K - 1) / DIV_K;
	localparam int SQ_IN_W  = 32 + F;
	localparam int RW       = (SQ_IN_W + 1) / 2;
	localparam int NSQ      = (RW + SQ_K - 1) / SQ_K;
	localparam int DEN_W    = ((RW > EPS_W) ? RW : EPS_W) + 1;
	localparam int SC_NUM_W = 32 + F;
	localparam int NSC      = (SC_NUM_W + DIV_K - 1) / DIV_K;
	localparam int PL_W     = 32 + LR_W - F;
	localparam int PV_W     = 33;
	localparam int VS_W     = ((PL_W > PV_W) ? PL_W : PV_W) + 2;

	localparam int ST_IN    = 0;
	localparam int ST_BDIV0 = 1;
	localparam int ST_MODQ  = 1;
	localparam int ST_MODR  = 2;
	localparam int ST_SLOT  = 3;
	localparam int ST_GDIV  = NB + 1;
	localparam int ST_G2    = NB + 2;
	localparam int ST_PB    = NB + 3;
	localparam int ST_PA    = NB + 4;
	localparam int ST_MS    = NB + 5;
	localparam int ST_DEN   = ST_MS + NSQ + 1;
	localparam int ST_SCL   = ST_DEN + NSC + 1;
	localparam int ST_MUL   = ST_SCL + 1;
	localparam int ST_VEL   = ST_MUL + 1;
	localparam int ST_WGT   = ST_VEL + 1;
	localparam int NSTG     = ST_WGT + 1;

	typedef struct packed {
		logic [PIDX_W-1:0]  pidx;
		logic [SW-1:0]      slot;
		logic [PIDX_W-1:0]  modq;
		logic [PIDX_W-1:0]  modr;
		logic               rec;
		logic               gneg;
		logic [31:0]        g_raw;
		logic [31:0]        w;
		logic [LR_W-1:0]    lr;
		logic [BATCH_W-1:0] bden;
		logic [31:0]        gmag;
		logic [31:0]        g2;
		logic [48:0]        pb;
		logic [48:0]        pa;
		logic [31:0]        ms;
		logic [DEN_W-1:0]   den;
		logic [31:0]        smag;
		logic               vneg;
		logic [PL_W-1:0]    pl;
		logic [PV_W-1:0]    pv;
		logic [31:0]        vel;
		logic [31:0]        wout;
		logic [31:0]        gout;
	} item_t;

	logic [16:0] mom_q;
	logic [16:0] alpha_q;
	logic [16:0] eps_q;
	logic        max_q;
	logic        acc_q;

	logic          clr_act_q;
	logic [SW-1:0] clr_q;

	item_t         ctx_q [NSTG];
	item_t         ctx_d [NSTG];
	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   rdy;
	logic            haz;

	logic [31:0] ms_mem  [NUM_PARAMS];
	logic [31:0] vel_mem [NUM_PARAMS];
	logic [31:0] ms_rd_q;
	logic [31:0] vel_rd_q;

	logic [31:0]          bdiv_quo;
	logic [RW-1:0]        sq_root;
	logic [SC_NUM_W-1:0]  sc_quo;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom_q   <= MOMENTUM_RST;
			alpha_q <= RMS_DECAY_RST;
			eps_q   <= EPSILON_RST;
			max_q   <= 1'b0;
			acc_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOMENTUM:  mom_q   <= (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
				REG_RMS_DECAY: alpha_q <= (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
				REG_EPSILON:   eps_q   <= cfg_data;
				REG_MAXIMIZE:  max_q   <= cfg_data[0];
				REG_ACCUM:     acc_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b1;
			clr_q     <= '0;
		end else if (clr_act_q) begin
			if (clr_q == SW'(NUM_PARAMS - 1)) begin
				clr_act_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// A non-recurrent beat at the hazard stage waits while an older non-recurrent beat of the same
	// slot is still between its mean-square read and its velocity write.
	always_comb begin
		haz = 1'b0;
		for (int k = ST_G2 + 1; k < ST_VEL; k++) begin
			if (vld_q[k] && !ctx_q[k].rec && (ctx_q[k].slot == ctx_q[ST_G2].slot)) begin
				haz = 1'b1;
			end
		end
		haz = haz && vld_q[ST_G2] && !ctx_q[ST_G2].rec;
	end

	always_comb begin
		rdy[NSTG] = m_tready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			if (k == ST_G2) begin
				rdy[k] = !vld_q[k] || (rdy[k+1] && !haz);
			end else begin
				rdy[k] = !vld_q[k] || rdy[k+1];
			end
		end
	end

	assign s_tready = rdy[0] && !clr_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid && !clr_act_q;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) begin
					if (k == ST_G2 + 1) begin
						vld_q[k] <= vld_q[k-1] && !haz;
					end else begin
						vld_q[k] <= vld_q[k-1];
					end
				end
			end
		end
	end

	always_comb begin
		logic [30:0]          mq;
		logic [26:0]          mr;
		logic [16:0]          sl;
		logic [63:0]          gp;
		logic [49:0]          mss;
		logic [DEN_W-1:0]     dd;
		logic [52:0]          plm;
		logic [48:0]          pvm;
		logic [31:0]          vmag;
		logic signed [VS_W-1:0] sa;
		logic signed [VS_W-1:0] sb;
		logic signed [VS_W-1:0] vs;
		logic signed [33:0]   nw;

		ctx_d[ST_IN]       = '0;
		ctx_d[ST_IN].pidx  = s_tdata[9:0];
		ctx_d[ST_IN].g_raw = s_tdata[41:10];
		ctx_d[ST_IN].w     = s_tdata[73:42];
		ctx_d[ST_IN].lr    = s_tdata[94:74];
		ctx_d[ST_IN].rec   = s_tuser;
		ctx_d[ST_IN].gneg  = s_tdata[41];
		ctx_d[ST_IN].gmag  = s_tdata[41] ? 32'(-s_tdata[41:10]) : s_tdata[41:10];
		ctx_d[ST_IN].bden  = (acc_q || (s_tdata[110:95] <= 16'd1)) ? 16'd1 : s_tdata[110:95];

		for (int k = 1; k < NSTG; k++) begin
			ctx_d[k] = ctx_q[k-1];
		end

		mq = 31'(ctx_q[ST_MODQ-1].pidx) * 31'(RCP);
		ctx_d[ST_MODQ].modq = mq[RCP_SH+PIDX_W-1:RCP_SH];

		mr = 27'(ctx_q[ST_MODR-1].modq) * 27'(NUM_PARAMS);
		ctx_d[ST_MODR].modr = ctx_q[ST_MODR-1].pidx - mr[PIDX_W-1:0];

		sl = 17'(ctx_q[ST_SLOT-1].modr);
		if (sl >= 17'(NUM_PARAMS)) begin
			sl = sl - 17'(NUM_PARAMS);
		end
		ctx_d[ST_SLOT].slot = sl[SW-1:0];

		ctx_d[ST_GDIV].gmag = bdiv_quo;

		gp = 64'(ctx_q[ST_G2-1].gmag) * 64'(ctx_q[ST_G2-1].gmag);
		ctx_d[ST_G2].g2 = (|gp[63:32+F]) ? 32'hFFFF_FFFF : gp[31+F:F];

		ctx_d[ST_PB].pb = 49'(ONE_Q16 - alpha_q) * 49'(ctx_q[ST_PB-1].g2);

		ctx_d[ST_PA].pa = 49'(alpha_q) * 49'(ms_rd_q);

		mss = 50'(ctx_q[ST_MS-1].pa) + 50'(ctx_q[ST_MS-1].pb);
		ctx_d[ST_MS].ms = (|mss[49:48]) ? 32'hFFFF_FFFF : mss[47:16];

		dd = DEN_W'(sq_root) + DEN_W'(eps_q);
		ctx_d[ST_DEN].den = (dd == '0) ? DEN_W'(1) : dd;

		if (|sc_quo[SC_NUM_W-1:31]) begin
			ctx_d[ST_SCL].smag = ctx_q[ST_SCL-1].gneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			ctx_d[ST_SCL].smag = {1'b0, sc_quo[30:0]};
		end

		plm  = 53'(ctx_q[ST_MUL-1].smag) * 53'(ctx_q[ST_MUL-1].lr);
		vmag = vel_rd_q[31] ? 32'(-vel_rd_q) : vel_rd_q;
		pvm  = 49'(vmag) * 49'(mom_q);
		ctx_d[ST_MUL].pl   = plm[52:F];
		ctx_d[ST_MUL].pv   = pvm[48:16];
		ctx_d[ST_MUL].vneg = vel_rd_q[31];

		sa = VS_W'(ctx_q[ST_VEL-1].pv);
		if (ctx_q[ST_VEL-1].vneg) begin
			sa = -sa;
		end
		sb = VS_W'(ctx_q[ST_VEL-1].pl);
		if (ctx_q[ST_VEL-1].gneg) begin
			sb = -sb;
		end
		vs = sa + sb;
		if (vs > $signed({{(VS_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
			ctx_d[ST_VEL].vel = 32'h7FFF_FFFF;
		end else if (vs < $signed({{(VS_W-32){1'b1}}, 32'h8000_0000})) begin
			ctx_d[ST_VEL].vel = 32'h8000_0000;
		end else begin
			ctx_d[ST_VEL].vel = vs[31:0];
		end

		if (max_q) begin
			nw = $signed({{2{ctx_q[ST_WGT-1].w[31]}}, ctx_q[ST_WGT-1].w})
				+ $signed({{2{ctx_q[ST_WGT-1].vel[31]}}, ctx_q[ST_WGT-1].vel});
		end else begin
			nw = $signed({{2{ctx_q[ST_WGT-1].w[31]}}, ctx_q[ST_WGT-1].w})
				- $signed({{2{ctx_q[ST_WGT-1].vel[31]}}, ctx_q[ST_WGT-1].vel});
		end
		if (ctx_q[ST_WGT-1].rec) begin
			ctx_d[ST_WGT].wout = ctx_q[ST_WGT-1].w;
			ctx_d[ST_WGT].gout = ctx_q[ST_WGT-1].g_raw;
		end else begin
			if (nw > 34'sh0_7FFF_FFFF) begin
				ctx_d[ST_WGT].wout = 32'h7FFF_FFFF;
			end else if (nw < -34'sh0_8000_0000) begin
				ctx_d[ST_WGT].wout = 32'h8000_0000;
			end else begin
				ctx_d[ST_WGT].wout = nw[31:0];
			end
			ctx_d[ST_WGT].gout = ctx_q[ST_WGT-1].gneg ? 32'(-ctx_q[ST_WGT-1].gmag)
				: ctx_q[ST_WGT-1].gmag;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTG; k++) begin
			if (rdy[k]) begin
				ctx_q[k] <= ctx_d[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_act_q) begin
			ms_mem[clr_q] <= '0;
		end else if (rdy[ST_MS] && vld_q[ST_MS-1] && !ctx_q[ST_MS-1].rec) begin
			ms_mem[ctx_q[ST_MS-1].slot] <= ctx_d[ST_MS].ms;
		end
		if (rdy[ST_PB]) begin
			ms_rd_q <= ms_mem[ctx_q[ST_G2].slot];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_act_q) begin
			vel_mem[clr_q] <= '0;
		end else if (rdy[ST_VEL] && vld_q[ST_VEL-1] && !ctx_q[ST_VEL-1].rec) begin
			vel_mem[ctx_q[ST_VEL-1].slot] <= ctx_d[ST_VEL].vel;
		end
		if (rdy[ST_SCL]) begin
			vel_rd_q <= vel_mem[ctx_q[ST_SCL-1].slot];
		end
	end

	rmsmu_div #(
		.NUM_W (32),
		.DEN_W (BATCH_W),
		.STEPS (DIV_K)
	) u_bdiv (
		.clk (clk),
		.en  (rdy[ST_BDIV0 +: NB]),
		.num (ctx_q[ST_IN].gmag),
		.den (ctx_q[ST_IN].bden),
		.quo (bdiv_quo)
	);

	rmsmu_sqrt #(
		.IN_W  (SQ_IN_W),
		.STEPS (SQ_K)
	) u_sqrt (
		.clk  (clk),
		.en   (rdy[ST_MS+1 +: NSQ]),
		.x    ({ctx_q[ST_MS].ms, {F{1'b0}}}),
		.root (sq_root)
	);

	rmsmu_div #(
		.NUM_W (SC_NUM_W),
		.DEN_W (DEN_W),
		.STEPS (DIV_K)
	) u_scdiv (
		.clk (clk),
		.en  (rdy[ST_DEN+1 +: NSC]),
		.num ({ctx_q[ST_DEN].gmag, {F{1'b0}}}),
		.den (ctx_q[ST_DEN].den),
		.quo (sc_quo)
	);

	assign m_tvalid = vld_q[ST_WGT];
	assign m_tdata  = {6'b0, ctx_q[ST_WGT].gout, ctx_q[ST_WGT].wout, ctx_q[ST_WGT].pidx};
	assign m_tuser  = !ctx_q[ST_WGT].rec;

endmodule

/* hdl/rmsmu_div.sv */
module rmsmu_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16,
	parameter int STEPS = 4,
	localparam int NST = (NUM_W + STEPS - 1) / STEPS
) (
	input  logic             clk,
	input  logic [NST-1:0]   en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	localparam int PAD_W = NST * STEPS;

	logic [DEN_W-1:0] rem_q [NST];
	logic [PAD_W-1:0] sh_q  [NST];
	logic [DEN_W-1:0] den_q [NST];
	logic [DEN_W-1:0] rem_i [NST];
	logic [PAD_W-1:0] sh_i  [NST];
	logic [DEN_W-1:0] den_i [NST];
	logic [DEN_W-1:0] rem_o [NST];
	logic [PAD_W-1:0] sh_o  [NST];

	for (genvar j = 0; j < NST; j++) begin : g_stg
		if (j == 0) begin : g_first
			assign rem_i[j] = '0;
			assign sh_i[j]  = PAD_W'(num);
			assign den_i[j] = den;
		end else begin : g_next
			assign rem_i[j] = rem_q[j-1];
			assign sh_i[j]  = sh_q[j-1];
			assign den_i[j] = den_q[j-1];
		end

		always_comb begin
			logic [DEN_W:0]   r;
			logic [DEN_W-1:0] rm;
			logic [PAD_W-1:0] sh;
			rm = rem_i[j];
			sh = sh_i[j];
			r  = '0;
			for (int s = 0; s < STEPS; s++) begin
				r  = {rm, sh[PAD_W-1]};
				sh = {sh[PAD_W-2:0], 1'b0};
				if (r >= {1'b0, den_i[j]}) begin
					r     = r - {1'b0, den_i[j]};
					sh[0] = 1'b1;
				end
				rm = r[DEN_W-1:0];
			end
			rem_o[j] = rm;
			sh_o[j]  = sh;
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_q[j] <= rem_o[j];
				sh_q[j]  <= sh_o[j];
				den_q[j] <= den_i[j];
			end
		end
	end

	assign quo = sh_q[NST-1][NUM_W-1:0];

endmodule

/* hdl/rmsmu_sqrt.sv */
module rmsmu_sqrt #(
	parameter int IN_W  = 48,
	parameter int STEPS = 3,
	localparam int RW  = (IN_W + 1) / 2,
	localparam int NST = (RW + STEPS - 1) / STEPS
) (
	input  logic            clk,
	input  logic [NST-1:0]  en,
	input  logic [IN_W-1:0] x,
	output logic [RW-1:0]   root
);

	localparam int PW = NST * STEPS;
	localparam int XW = 2 * PW;

	logic [PW+1:0] rem_q [NST];
	logic [PW-1:0] rt_q  [NST];
	logic [XW-1:0] xs_q  [NST];
	logic [PW+1:0] rem_i [NST];
	logic [PW-1:0] rt_i  [NST];
	logic [XW-1:0] xs_i  [NST];
	logic [PW+1:0] rem_o [NST];
	logic [PW-1:0] rt_o  [NST];
	logic [XW-1:0] xs_o  [NST];

	for (genvar j = 0; j < NST; j++) begin : g_stg
		if (j == 0) begin : g_first
			assign rem_i[j] = '0;
			assign rt_i[j]  = '0;
			assign xs_i[j]  = XW'(x);
		end else begin : g_next
			assign rem_i[j] = rem_q[j-1];
			assign rt_i[j]  = rt_q[j-1];
			assign xs_i[j]  = xs_q[j-1];
		end

		always_comb begin
			logic [PW+3:0] t;
			logic [PW+3:0] tr;
			logic [PW+1:0] rm;
			logic [PW-1:0] rt;
			logic [XW-1:0] xs;
			rm = rem_i[j];
			rt = rt_i[j];
			xs = xs_i[j];
			t  = '0;
			tr = '0;
			for (int s = 0; s < STEPS; s++) begin
				t  = {rm, xs[XW-1:XW-2]};
				xs = {xs[XW-3:0], 2'b00};
				tr = {2'b00, rt, 2'b01};
				if (t >= tr) begin
					t  = t - tr;
					rt = {rt[PW-2:0], 1'b1};
				end else begin
					rt = {rt[PW-2:0], 1'b0};
				end
				rm = t[PW+1:0];
			end
			rem_o[j] = rm;
			rt_o[j]  = rt;
			xs_o[j]  = xs;
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_q[j] <= rem_o[j];
				rt_q[j]  <= rt_o[j];
				xs_q[j]  <= xs_o[j];
			end
		end
	end

	assign root = rt_q[NST-1][RW-1:0];

endmodule
